// File: hdl/nsf_pkg.sv
// ----------------------------------------------------------------------------
// nsf_pkg
// Shared constants, types and codes of the NMEA sentence filter.
// ----------------------------------------------------------------------------
package nsf_pkg;

   localparam int LINE_CAPACITY = 128;
   localparam int WORD_BYTES    = 8;
   localparam int MIN_TEXT      = 7;
   localparam int PREFIX_BYTES  = 6;
   localparam int MAX_WORDS     = 16;
   localparam int PREFIX_W      = 48;
   localparam int CSR_IDX_W     = 1;

   localparam logic [7:0] START_CHAR = 8'h24;
   localparam logic [7:0] END_CHAR   = 8'h0A;

   localparam logic [PREFIX_W-1:0] PREFIX_A_RST = 48'h244750474741;
   localparam logic [PREFIX_W-1:0] PREFIX_B_RST = 48'h244750524D43;

   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_A = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_B = 1'b1;

   // fill index; at least four bits so that row and lane split cleanly
   localparam int IDX_W    = ($clog2(LINE_CAPACITY) < 4) ? 4 : $clog2(LINE_CAPACITY);
   localparam int ROW_W    = IDX_W - 3;
   localparam int MEM_ROWS = 2 ** ROW_W;

   // longest text sent: capped by the store and by the word limit
   localparam int MAX_TEXT = ((LINE_CAPACITY - 1) < (MAX_WORDS * WORD_BYTES)) ?
                             (LINE_CAPACITY - 1) : (MAX_WORDS * WORD_BYTES);
   localparam int LEN_W    = $clog2(MAX_TEXT + 1);

   typedef struct packed {
      logic             en;
      logic [ROW_W-1:0] row;
      logic [2:0]       lane;
      logic [7:0]       data;
   } mem_wr_type;

   typedef struct packed {
      logic             valid;
      logic [LEN_W-1:0] len;
   } job_type;

   typedef enum logic [1:0] {
      DRN_IDLE,
      DRN_READ,
      DRN_SEND
   } drain_state_type;

endpackage

// File: hdl/nmea_sentence_filter.sv
// ----------------------------------------------------------------------------
// nmea_sentence_filter
// Frames GPS receiver bytes into NMEA sentences and sends the sentences whose
// six-byte head matches one of two prefixes as packed eight-byte words.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid/req_stall    req_data_byte[7:0]
//  rsp      out        rsp_valid/rsp_stall    packed_bytes, byte_count, last_word
//  csr      in         csr_write_en           csr_index, csr_write_data[47:0]
//
// After a newline that closes an accepted sentence the drain sends N words, each
// by one store row read, then send, and input is held off until they and any
// rsp_stall are through; N is at most 16. Reset clears the line state and loads
// the default prefixes; the store itself is not cleared. req_stall is high while
// a sentence is being drained.
// ----------------------------------------------------------------------------
module nmea_sentence_filter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [63:0]                   rsp_packed_bytes,
   output logic [3:0]                    rsp_byte_count,
   output logic                          rsp_last_word,
   input  logic                          csr_write_en,
   input  logic [nsf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nsf_pkg::PREFIX_W-1:0]  csr_write_data
);

   nsf_pkg::mem_wr_type       mem_wr;
   nsf_pkg::job_type          job;
   logic                      busy;
   logic                      job_empty;
   logic                      job_pop;
   logic [nsf_pkg::LEN_W-1:0] job_len;

   nsf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .busy           (busy),
      .mem_wr         (mem_wr),
      .job            (job)
   );

   nsf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job),
      .pop      (job_pop),
      .empty    (job_empty),
      .head_len (job_len)
   );

   nsf_drain u_drain (
      .clock            (clock),
      .reset            (reset),
      .mem_wr           (mem_wr),
      .job_empty        (job_empty),
      .job_len          (job_len),
      .job_pop          (job_pop),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_packed_bytes (rsp_packed_bytes),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_last_word    (rsp_last_word)
   );

   // no byte is taken while a sentence is going out
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !rsp_valid)
      else $error("byte accepted while a word is pending");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_count != 4'd0) && (rsp_byte_count <= 4'd8))
      else $error("word byte count out of range");

   a_full_words: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_word) |-> (rsp_byte_count == 4'd8))
      else $error("short word before the last word");

   a_word_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("words sent back to back from one store port");

endmodule

// File: hdl/nsf_front.sv
// ----------------------------------------------------------------------------
// nsf_front
// Takes received bytes, tracks the line, writes the store and posts a drain
// job for every accepted sentence.
// ----------------------------------------------------------------------------
module nsf_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_data_byte,
   input  logic                              csr_write_en,
   input  logic [nsf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [nsf_pkg::PREFIX_W-1:0]      csr_write_data,
   input  logic                              busy,
   output nsf_pkg::mem_wr_type               mem_wr,
   output nsf_pkg::job_type                  job
);

   logic [nsf_pkg::PREFIX_W-1:0] prefix_a_ff, prefix_a_in;
   logic [nsf_pkg::PREFIX_W-1:0] prefix_b_ff, prefix_b_in;
   logic [nsf_pkg::PREFIX_W-1:0] head_ff, head_in;
   logic [nsf_pkg::IDX_W-1:0]    fill_ff, fill_in;
   logic [nsf_pkg::IDX_W-1:0]    text_ff, text_in;
   logic                         zero_ff, zero_in;

   logic                         accept;
   logic                         restart;
   logic [nsf_pkg::IDX_W-1:0]    fill_base;
   logic [nsf_pkg::IDX_W-1:0]    text_base;
   logic [nsf_pkg::IDX_W-1:0]    text_new;
   logic                         zero_base;
   logic                         head_match;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   always_comb begin
      prefix_a_in = prefix_a_ff;
      prefix_b_in = prefix_b_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            nsf_pkg::CSR_PREFIX_A: prefix_a_in = csr_write_data;
            nsf_pkg::CSR_PREFIX_B: prefix_b_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      restart = ((req_data_byte == nsf_pkg::START_CHAR) && (fill_ff != '0)) ||
                (fill_ff >= nsf_pkg::IDX_W'(nsf_pkg::LINE_CAPACITY - 1));
      fill_base = restart ? '0 : fill_ff;
      text_base = restart ? '0 : text_ff;
      zero_base = restart ? 1'b0 : zero_ff;
      text_new  = (zero_base || (req_data_byte == 8'h00)) ? text_base
                                                          : text_base + 1'b1;
      head_match = (head_ff == prefix_a_ff) || (head_ff == prefix_b_ff);

      // keep the first six bytes aside for the prefix check
      head_in = head_ff;
      for (int k = 0; k < nsf_pkg::PREFIX_BYTES; k++) begin
         if (accept && (fill_base == nsf_pkg::IDX_W'(k))) begin
            head_in[(nsf_pkg::PREFIX_BYTES-1-k)*8 +: 8] = req_data_byte;
         end
      end

      fill_in = fill_ff;
      text_in = text_ff;
      zero_in = zero_ff;
      job     = '0;
      if (accept) begin
         if (req_data_byte == nsf_pkg::END_CHAR) begin
            fill_in   = '0;
            text_in   = '0;
            zero_in   = 1'b0;
            job.valid = (text_new >= nsf_pkg::IDX_W'(nsf_pkg::MIN_TEXT)) && head_match;
            job.len   = (text_new > nsf_pkg::IDX_W'(nsf_pkg::MAX_TEXT)) ?
                        nsf_pkg::LEN_W'(nsf_pkg::MAX_TEXT) : nsf_pkg::LEN_W'(text_new);
         end else begin
            fill_in = fill_base + 1'b1;
            text_in = text_new;
            zero_in = zero_base || (req_data_byte == 8'h00);
         end
      end

      mem_wr.en   = accept;
      mem_wr.row  = fill_base[nsf_pkg::IDX_W-1:3];
      mem_wr.lane = fill_base[2:0];
      mem_wr.data = req_data_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_a_ff <= nsf_pkg::PREFIX_A_RST;
         prefix_b_ff <= nsf_pkg::PREFIX_B_RST;
         fill_ff     <= '0;
         text_ff     <= '0;
         zero_ff     <= 1'b0;
      end else begin
         prefix_a_ff <= prefix_a_in;
         prefix_b_ff <= prefix_b_in;
         fill_ff     <= fill_in;
         text_ff     <= text_in;
         zero_ff     <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
   end

endmodule

// File: hdl/nsf_queue.sv
// ----------------------------------------------------------------------------
// nsf_queue
// Two-entry job queue between the byte front and the word drain.
// ----------------------------------------------------------------------------
module nsf_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  nsf_pkg::job_type          push,
   input  logic                      pop,
   output logic                      empty,
   output logic [nsf_pkg::LEN_W-1:0] head_len
);

   logic [nsf_pkg::LEN_W-1:0] slot_ff [2];
   logic                      wr_ptr_ff, wr_ptr_in;
   logic                      rd_ptr_ff, rd_ptr_in;
   logic [1:0]                count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign empty    = (count_ff == 2'd0);
   assign head_len = slot_ff[rd_ptr_ff];
   assign do_push  = push.valid && (count_ff != 2'd2);
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.len;
      end
   end

endmodule

// File: hdl/nsf_drain.sv
// ----------------------------------------------------------------------------
// nsf_drain
// Holds the line store and sends an accepted sentence as packed words,
// one store row per word.
// ----------------------------------------------------------------------------
module nsf_drain (
   input  logic                      clock,
   input  logic                      reset,
   input  nsf_pkg::mem_wr_type       mem_wr,
   input  logic                      job_empty,
   input  logic [nsf_pkg::LEN_W-1:0] job_len,
   output logic                      job_pop,
   output logic                      busy,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [63:0]               rsp_packed_bytes,
   output logic [3:0]                rsp_byte_count,
   output logic                      rsp_last_word
);

   logic [63:0]                 mem [nsf_pkg::MEM_ROWS];
   logic [63:0]                 rd_ff;

   nsf_pkg::drain_state_type    state_ff, state_in;
   logic [nsf_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [nsf_pkg::LEN_W-1:0]   remain_ff, remain_in;
   logic                        last;
   logic [3:0]                  count;

   assign last  = (remain_ff <= nsf_pkg::LEN_W'(nsf_pkg::WORD_BYTES - 1)) ||
                  (int'(remain_ff) == nsf_pkg::WORD_BYTES);
   assign count = last ? 4'(remain_ff) : 4'(nsf_pkg::WORD_BYTES);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nsf_pkg::DRN_IDLE: if (!job_empty) state_in = nsf_pkg::DRN_READ;
         nsf_pkg::DRN_READ: state_in = nsf_pkg::DRN_SEND;
         nsf_pkg::DRN_SEND: begin
            if (!rsp_stall) state_in = last ? nsf_pkg::DRN_IDLE : nsf_pkg::DRN_READ;
         end
         default: state_in = nsf_pkg::DRN_IDLE;
      endcase
   end

   // outputs and counters
   always_comb begin
      job_pop   = 1'b0;
      rsp_valid = 1'b0;
      row_in    = row_ff;
      remain_in = remain_ff;
      unique case (state_ff)
         nsf_pkg::DRN_IDLE: begin
            job_pop   = !job_empty;
            row_in    = '0;
            remain_in = job_len;
         end
         nsf_pkg::DRN_READ: ;
         nsf_pkg::DRN_SEND: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               row_in    = row_ff + 1'b1;
               remain_in = remain_ff - nsf_pkg::LEN_W'(nsf_pkg::WORD_BYTES);
            end
         end
         default: ;
      endcase
      busy = (state_ff != nsf_pkg::DRN_IDLE) || !job_empty;
   end

   // blank byte lanes past the end of the text
   always_comb begin
      for (int k = 0; k < nsf_pkg::WORD_BYTES; k++) begin
         rsp_packed_bytes[k*8 +: 8] = (4'(k) < count) ? rd_ff[k*8 +: 8] : 8'h00;
      end
      rsp_byte_count = count;
      rsp_last_word  = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nsf_pkg::DRN_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff    <= row_in;
      remain_ff <= remain_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         mem[mem_wr.row][{mem_wr.lane, 3'b000} +: 8] <= mem_wr.data;
      end
      if (state_ff == nsf_pkg::DRN_READ) begin
         rd_ff <= mem[row_ff];
      end
   end

endmodule
